### rtl/core/atbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atbb_pkg
// Shared types and codes for the affine transform / bounding box block.
// ----------------------------------------------------------------------------
package atbb_pkg;

    // configuration register indexes
    localparam int NUM_CFG   = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;
    localparam int FIELD_W   = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW0_XY = 3'd0,
        CFG_ROW0_ZT = 3'd1,
        CFG_ROW1_XY = 3'd2,
        CFG_ROW1_ZT = 3'd3,
        CFG_ROW2_XY = 3'd4,
        CFG_ROW2_ZT = 3'd5
    } cfg_index_t;

    // one incoming vertex word
    typedef struct packed {
        logic signed [FIELD_W-1:0] pos_x;
        logic signed [FIELD_W-1:0] pos_y;
        logic signed [FIELD_W-1:0] pos_z;
        logic                      final_vertex;
    } vtx_word_t;

    // one result word
    typedef struct packed {
        logic signed [FIELD_W-1:0] world_x;
        logic signed [FIELD_W-1:0] world_y;
        logic signed [FIELD_W-1:0] world_z;
        logic signed [FIELD_W-1:0] box_min_x;
        logic signed [FIELD_W-1:0] box_min_y;
        logic signed [FIELD_W-1:0] box_min_z;
        logic signed [FIELD_W-1:0] box_max_x;
        logic signed [FIELD_W-1:0] box_max_y;
        logic signed [FIELD_W-1:0] box_max_z;
        logic                      bounds_valid;
    } res_word_t;

    // per-stage load strobes from the pipeline control
    typedef struct packed {
        logic ld2;   // product stage
        logic ld3;   // sum stage
        logic ld4;   // round / translate / saturate stage
        logic ld5;   // bounds and result stage
    } pipe_ctrl_t;

endpackage

### rtl/core/atbb_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atbb_axis
// One row of the affine transform: three products, exact sum with rounding,
// translation and saturation, over three registered stages.
// ----------------------------------------------------------------------------
module atbb_axis #(
    parameter int CW = 32,
    parameter int FB = 16
) (
    input  logic                 clk,
    input  atbb_pkg::pipe_ctrl_t ctrl,
    input  logic signed [CW-1:0] coef_x,
    input  logic signed [CW-1:0] coef_y,
    input  logic signed [CW-1:0] coef_z,
    input  logic signed [CW-1:0] offset,
    input  logic signed [CW-1:0] pos_x,
    input  logic signed [CW-1:0] pos_y,
    input  logic signed [CW-1:0] pos_z,
    output logic signed [CW-1:0] world
);
    import atbb_pkg::*;

    localparam int PROD_W = 2 * CW;
    localparam int SUM_W  = 2 * CW + 2;
    localparam int ACC_W  = SUM_W + 1;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(72'd1 << (FB - 1));
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        {{(ACC_W-CW+1){1'b1}}, {(CW-1){1'b0}}};

    logic signed [PROD_W-1:0] prod_x_reg, prod_y_reg, prod_z_reg;
    logic signed [PROD_W-1:0] prod_x_next, prod_y_next, prod_z_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [SUM_W-1:0]  scaled;
    logic signed [ACC_W-1:0]  acc;
    logic signed [CW-1:0]     world_reg, world_next;

    assign prod_x_next = coef_x * pos_x;
    assign prod_y_next = coef_y * pos_y;
    assign prod_z_next = coef_z * pos_z;

    // exact sum plus half an LSB of the result: the shift below then rounds
    assign sum_next = SUM_W'(prod_x_reg) + SUM_W'(prod_y_reg) + SUM_W'(prod_z_reg)
                    + ROUND_HALF;

    assign scaled = sum_reg >>> FB;
    assign acc    = ACC_W'(scaled) + ACC_W'(offset);

    always_comb
    begin
        if (acc > SAT_MAX)
        begin
            world_next = {1'b0, {(CW-1){1'b1}}};
        end
        else if (acc < SAT_MIN)
        begin
            world_next = {1'b1, {(CW-1){1'b0}}};
        end
        else
        begin
            world_next = acc[CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld2)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            prod_z_reg <= prod_z_next;
        end
        if (ctrl.ld3)
        begin
            sum_reg <= sum_next;
        end
        if (ctrl.ld4)
        begin
            world_reg <= world_next;
        end
    end

    assign world = world_reg;

endmodule

### rtl/core/atbb_bounds.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atbb_bounds
// Running per-axis minimum and maximum, and the result register.
// ----------------------------------------------------------------------------
module atbb_bounds #(
    parameter int CW = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  atbb_pkg::pipe_ctrl_t ctrl,
    input  logic                 last,
    input  logic signed [CW-1:0] wx,
    input  logic signed [CW-1:0] wy,
    input  logic signed [CW-1:0] wz,
    output atbb_pkg::res_word_t  res
);
    import atbb_pkg::*;

    localparam logic signed [CW-1:0] POS_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] NEG_MIN = {1'b1, {(CW-1){1'b0}}};

    logic signed [CW-1:0] min_x_reg, min_y_reg, min_z_reg;
    logic signed [CW-1:0] max_x_reg, max_y_reg, max_z_reg;
    logic signed [CW-1:0] min_x_next, min_y_next, min_z_next;
    logic signed [CW-1:0] max_x_next, max_y_next, max_z_next;
    res_word_t            res_reg, res_next;

    // extremes including the current vertex
    assign min_x_next = (wx < min_x_reg) ? wx : min_x_reg;
    assign min_y_next = (wy < min_y_reg) ? wy : min_y_reg;
    assign min_z_next = (wz < min_z_reg) ? wz : min_z_reg;
    assign max_x_next = (wx > max_x_reg) ? wx : max_x_reg;
    assign max_y_next = (wy > max_y_reg) ? wy : max_y_reg;
    assign max_z_next = (wz > max_z_reg) ? wz : max_z_reg;

    always_comb
    begin
        res_next         = '0;
        res_next.world_x = FIELD_W'(wx);
        res_next.world_y = FIELD_W'(wy);
        res_next.world_z = FIELD_W'(wz);
        if (last)
        begin
            res_next.box_min_x    = FIELD_W'(min_x_next);
            res_next.box_min_y    = FIELD_W'(min_y_next);
            res_next.box_min_z    = FIELD_W'(min_z_next);
            res_next.box_max_x    = FIELD_W'(max_x_next);
            res_next.box_max_y    = FIELD_W'(max_y_next);
            res_next.box_max_z    = FIELD_W'(max_z_next);
            res_next.bounds_valid = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= POS_MAX;
            min_y_reg <= POS_MAX;
            min_z_reg <= POS_MAX;
            max_x_reg <= NEG_MIN;
            max_y_reg <= NEG_MIN;
            max_z_reg <= NEG_MIN;
        end
        else if (ctrl.ld5)
        begin
            if (last)
            begin
                min_x_reg <= POS_MAX;
                min_y_reg <= POS_MAX;
                min_z_reg <= POS_MAX;
                max_x_reg <= NEG_MIN;
                max_y_reg <= NEG_MIN;
                max_z_reg <= NEG_MIN;
            end
            else
            begin
                min_x_reg <= min_x_next;
                min_y_reg <= min_y_next;
                min_z_reg <= min_z_next;
                max_x_reg <= max_x_next;
                max_y_reg <= max_y_next;
                max_z_reg <= max_z_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld5)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

### rtl/core/affine_transform_bounding_box.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_transform_bounding_box
// Affine transform of a vertex stream with a running axis-aligned box.
// ----------------------------------------------------------------------------
// Usage:
//   vtx_valid / vtx_ready / vtx_data carry one vertex word per handshake
//   (Q16.16 position plus a final_vertex mark). res_valid / res_ready /
//   res_data return exactly one result word per vertex, in order: the
//   transformed, saturated position, and on the final vertex the bounding
//   box of every vertex since the previous final one (this one included).
//   cfg_wr_en / cfg_index / cfg_data write the six 64-bit matrix registers;
//   write them only while no vertex is in flight. Indexes above the list
//   are dropped.
//   A vertex passes through the five-stage pipeline (input, products,
//   sum, round/saturate, bounds/result) to res_valid. Throughput: one
//   vertex per cycle while the receiver does not stall.
//   Reset loads the identity matrix, empties the pipeline and seeds the
//   running extremes. When the receiver stalls, each stage holds only if the
//   one after it is full, so bubbles still fill and vtx_ready drops only once
//   all five stages hold a word.
// ----------------------------------------------------------------------------
module affine_transform_bounding_box #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 vtx_valid,
    output logic                                 vtx_ready,
    input  atbb_pkg::vtx_word_t                  vtx_data,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output atbb_pkg::res_word_t                  res_data,
    input  logic                                 cfg_wr_en,
    input  logic [atbb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [atbb_pkg::CFG_W-1:0]           cfg_data
);
    import atbb_pkg::*;

    localparam int CW = COORD_WIDTH;

    // 1.0 in the configured fraction format, placed in either register half
    localparam logic [FIELD_W-1:0] ONE_FX   = FIELD_W'(64'd1 << FRACTION_BITS);
    localparam logic [CFG_W-1:0]   ONE_HIGH = {ONE_FX, {FIELD_W{1'b0}}};
    localparam logic [CFG_W-1:0]   ONE_LOW  = {{FIELD_W{1'b0}}, ONE_FX};

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0] row0_xy_reg, row0_zt_reg;
    logic [CFG_W-1:0] row1_xy_reg, row1_zt_reg;
    logic [CFG_W-1:0] row2_xy_reg, row2_zt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_xy_reg <= ONE_HIGH;
            row0_zt_reg <= '0;
            row1_xy_reg <= ONE_LOW;
            row1_zt_reg <= '0;
            row2_xy_reg <= '0;
            row2_zt_reg <= ONE_HIGH;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ROW0_XY: row0_xy_reg <= cfg_data;
                CFG_ROW0_ZT: row0_zt_reg <= cfg_data;
                CFG_ROW1_XY: row1_xy_reg <= cfg_data;
                CFG_ROW1_ZT: row1_zt_reg <= cfg_data;
                CFG_ROW2_XY: row2_xy_reg <= cfg_data;
                CFG_ROW2_ZT: row2_zt_reg <= cfg_data;
                default:     ;   // out-of-range index: drop the write
            endcase
        end
    end

    // coefficients: low CW bits of each 32-bit half, taken as signed
    logic signed [CW-1:0] m00, m01, m02, tx;
    logic signed [CW-1:0] m10, m11, m12, ty;
    logic signed [CW-1:0] m20, m21, m22, tz;

    assign m00 = row0_xy_reg[FIELD_W +: CW];
    assign m01 = row0_xy_reg[0 +: CW];
    assign m02 = row0_zt_reg[FIELD_W +: CW];
    assign tx  = row0_zt_reg[0 +: CW];
    assign m10 = row1_xy_reg[FIELD_W +: CW];
    assign m11 = row1_xy_reg[0 +: CW];
    assign m12 = row1_zt_reg[FIELD_W +: CW];
    assign ty  = row1_zt_reg[0 +: CW];
    assign m20 = row2_xy_reg[FIELD_W +: CW];
    assign m21 = row2_xy_reg[0 +: CW];
    assign m22 = row2_zt_reg[FIELD_W +: CW];
    assign tz  = row2_zt_reg[0 +: CW];

    // ---------------- pipeline control ----------------
    // Stage k advances when it is empty or stage k+1 advances.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic ld1;
    pipe_ctrl_t ctrl;

    assign rdy5 = !v5_reg || res_ready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign vtx_ready = rdy1;
    assign ld1       = rdy1 && vtx_valid;
    assign ctrl.ld2  = rdy2 && v1_reg;
    assign ctrl.ld3  = rdy3 && v2_reg;
    assign ctrl.ld4  = rdy4 && v3_reg;
    assign ctrl.ld5  = rdy5 && v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= vtx_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // ---------------- input register and final-vertex mark ----------------
    logic signed [CW-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic                 last1_reg, last2_reg, last3_reg, last4_reg;

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            pos_x_reg <= vtx_data.pos_x[CW-1:0];
            pos_y_reg <= vtx_data.pos_y[CW-1:0];
            pos_z_reg <= vtx_data.pos_z[CW-1:0];
            last1_reg <= vtx_data.final_vertex;
        end
        if (ctrl.ld2) last2_reg <= last1_reg;
        if (ctrl.ld3) last3_reg <= last2_reg;
        if (ctrl.ld4) last4_reg <= last3_reg;
    end

    // ---------------- transform rows ----------------
    logic signed [CW-1:0] wx, wy, wz;

    atbb_axis #(.CW(CW), .FB(FRACTION_BITS)) u_axis_x (
        .clk    (clk),
        .ctrl   (ctrl),
        .coef_x (m00),
        .coef_y (m01),
        .coef_z (m02),
        .offset (tx),
        .pos_x  (pos_x_reg),
        .pos_y  (pos_y_reg),
        .pos_z  (pos_z_reg),
        .world  (wx)
    );

    atbb_axis #(.CW(CW), .FB(FRACTION_BITS)) u_axis_y (
        .clk    (clk),
        .ctrl   (ctrl),
        .coef_x (m10),
        .coef_y (m11),
        .coef_z (m12),
        .offset (ty),
        .pos_x  (pos_x_reg),
        .pos_y  (pos_y_reg),
        .pos_z  (pos_z_reg),
        .world  (wy)
    );

    atbb_axis #(.CW(CW), .FB(FRACTION_BITS)) u_axis_z (
        .clk    (clk),
        .ctrl   (ctrl),
        .coef_x (m20),
        .coef_y (m21),
        .coef_z (m22),
        .offset (tz),
        .pos_x  (pos_x_reg),
        .pos_y  (pos_y_reg),
        .pos_z  (pos_z_reg),
        .world  (wz)
    );

    // ---------------- running box and result register ----------------
    atbb_bounds #(.CW(CW)) u_bounds (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .last  (last4_reg),
        .wx    (wx),
        .wy    (wy),
        .wz    (wz),
        .res   (res_data)
    );

    assign res_valid = v5_reg;

    // ---------------- assertions ----------------
    // an empty result stage must never back-pressure the source
    a_ready_when_out_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !res_valid |-> vtx_ready
    ) else $error("vtx_ready low while result stage is empty");

    // a final box always contains at least the final vertex
    a_box_ordered: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.bounds_valid) |->
            ($signed(res_data.box_min_x) <= $signed(res_data.box_max_x)) &&
            ($signed(res_data.box_min_y) <= $signed(res_data.box_max_y)) &&
            ($signed(res_data.box_min_z) <= $signed(res_data.box_max_z))
    ) else $error("bounding box minimum above maximum");

    a_box_holds_vertex: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.bounds_valid) |->
            ($signed(res_data.box_min_x) <= $signed(res_data.world_x)) &&
            ($signed(res_data.world_x) <= $signed(res_data.box_max_x)) &&
            ($signed(res_data.box_min_y) <= $signed(res_data.world_y)) &&
            ($signed(res_data.world_y) <= $signed(res_data.box_max_y)) &&
            ($signed(res_data.box_min_z) <= $signed(res_data.world_z)) &&
            ($signed(res_data.world_z) <= $signed(res_data.box_max_z))
    ) else $error("final vertex outside its bounding box");

    // box fields stay zero on ordinary vertices
    a_box_zero_when_not_final: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && !res_data.bounds_valid) |->
            (res_data.box_min_x == '0) && (res_data.box_min_y == '0) &&
            (res_data.box_min_z == '0) && (res_data.box_max_x == '0) &&
            (res_data.box_max_y == '0) && (res_data.box_max_z == '0)
    ) else $error("box fields nonzero on a non-final vertex");

endmodule

### dv/affine_transform_bounding_box_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_transform_bounding_box_test
// Self-checking bench for the vertex transform and bounding box block.
// ----------------------------------------------------------------------------
// A directed table of vertices is walked under the reset (identity) matrix
// with typed-in results, then under saturating and half-step matrices against
// the predictor. Random meshes follow under random matrices, in three phases
// of sender/receiver idling, with a long receiver hold-off that backs up the
// pipeline and pauses that drain it. Every result word is compared field by
// field with the oldest expected word.
// ----------------------------------------------------------------------------
module affine_transform_bounding_box_test;

    import atbb_pkg::*;

    localparam int Q_FRAC          = 16;
    localparam int RES_W           = $bits(res_word_t);
    localparam int NUM_ROWS        = 6;
    localparam int NUM_MATS        = 4;
    localparam int NUM_PHASES      = 3;
    localparam int SEGS_PER_PHASE  = 4;
    localparam int SEG_ITEMS       = 138;
    localparam int MAX_MESH        = 24;
    localparam int SETTLE_CYCLES   = 8;
    localparam int RX_HOLD_CYCLES  = 60;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PRINT_LIMIT     = 100;

    localparam logic signed [FIELD_W-1:0] Q_MAX     = 32'sh7fff_ffff;
    localparam logic signed [FIELD_W-1:0] Q_MIN     = 32'sh8000_0000;
    localparam logic signed [FIELD_W-1:0] Q_ONE     = 32'sh0001_0000;
    localparam logic signed [FIELD_W-1:0] Q_HALF    = 32'sh0000_8000;
    localparam logic [FIELD_W-1:0]        COEF_SPAN  = 32'h0002_0000;  // +/-2.0
    localparam logic [FIELD_W-1:0]        COORD_SPAN = 32'h03e8_0000;  // +/-1000.0

    localparam logic signed [69:0] SAT_HI   = 70'sd2147483647;
    localparam logic signed [69:0] SAT_LO   = -70'sd2147483648;
    localparam logic signed [69:0] ROUND_UP = 70'sd32768;

    // register indexes past the end of the list; writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(NUM_CFG);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(NUM_CFG + 1);

    typedef enum int { PICK_SMALL, PICK_FULL, PICK_EDGE } pick_t;

    typedef struct {
        vtx_word_t vtx;
        res_word_t gold;
    } vertex_case_t;

    // ------------------------------------------------------------------------
    // clock, DUT and driven signals
    // ------------------------------------------------------------------------
    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 vtx_valid  = 1'b0;
    logic                 vtx_ready;
    vtx_word_t            vtx_data   = '0;
    logic                 res_valid;
    logic                 res_ready  = 1'b0;
    res_word_t            res_data;
    logic                 cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [CFG_W-1:0]     cfg_data   = '0;

    // golden word riding along with the vertex word it belongs to
    logic                 vtx_gold_on = 1'b0;
    res_word_t            vtx_gold    = '0;

    always #1 clk = ~clk;

    affine_transform_bounding_box dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx_valid (vtx_valid),
        .vtx_ready (vtx_ready),
        .vtx_data  (vtx_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // predictor state: mirrored matrix registers and running extremes
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0]          matrix_regs [NUM_CFG];
    logic signed [FIELD_W-1:0] box_lo [3];
    logic signed [FIELD_W-1:0] box_hi [3];
    res_word_t                 expected_results [$];
    int                        mismatch_count = 0;

    string RESULT_FIELDS [9] = '{"world_x", "world_y", "world_z",
                                 "box_min_x", "box_min_y", "box_min_z",
                                 "box_max_x", "box_max_y", "box_max_z"};

    // Return the extremes to their seeds so any first vertex replaces them.
    function automatic void clear_box();
        for (int a = 0; a < 3; a++)
        begin
            box_lo[a] = Q_MAX;
            box_hi[a] = Q_MIN;
        end
    endfunction

    // One row of the matrix: exact sum of products, round half up, add the
    // translation, saturate to the signed 32-bit range.
    function automatic logic signed [FIELD_W-1:0] transform_axis(
        logic [CFG_W-1:0] rxy, logic [CFG_W-1:0] rzt,
        logic signed [FIELD_W-1:0] x, logic signed [FIELD_W-1:0] y,
        logic signed [FIELD_W-1:0] z);
        logic signed [69:0] c0, c1, c2, tr, px, py, pz, acc;
        c0 = $signed(rxy[63:32]);
        c1 = $signed(rxy[31:0]);
        c2 = $signed(rzt[63:32]);
        tr = $signed(rzt[31:0]);
        px = x;
        py = y;
        pz = z;
        acc = c0 * px + c1 * py + c2 * pz + ROUND_UP;
        acc = (acc >>> Q_FRAC) + tr;
        if (acc > SAT_HI)
            return Q_MAX;
        if (acc < SAT_LO)
            return Q_MIN;
        return acc[FIELD_W-1:0];
    endfunction

    // Transform one vertex, fold it into the running box and, on the final
    // vertex, hand out the box and reseed the extremes.
    function automatic res_word_t transform_vertex(vtx_word_t v);
        logic signed [FIELD_W-1:0] w [3];
        res_word_t r;
        w[0] = transform_axis(matrix_regs[CFG_ROW0_XY], matrix_regs[CFG_ROW0_ZT],
                              v.pos_x, v.pos_y, v.pos_z);
        w[1] = transform_axis(matrix_regs[CFG_ROW1_XY], matrix_regs[CFG_ROW1_ZT],
                              v.pos_x, v.pos_y, v.pos_z);
        w[2] = transform_axis(matrix_regs[CFG_ROW2_XY], matrix_regs[CFG_ROW2_ZT],
                              v.pos_x, v.pos_y, v.pos_z);
        for (int a = 0; a < 3; a++)
        begin
            if (w[a] < box_lo[a])
                box_lo[a] = w[a];
            if (w[a] > box_hi[a])
                box_hi[a] = w[a];
        end
        r = '0;
        r.world_x = w[0];
        r.world_y = w[1];
        r.world_z = w[2];
        if (v.final_vertex)
        begin
            r.box_min_x    = box_lo[0];
            r.box_min_y    = box_lo[1];
            r.box_min_z    = box_lo[2];
            r.box_max_x    = box_hi[0];
            r.box_max_y    = box_hi[1];
            r.box_max_z    = box_hi[2];
            r.bounds_valid = 1'b1;
            clear_box();
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_result(res_word_t got, res_word_t want);
        for (int i = 0; i < 9; i++)
        begin
            if (got[RES_W-1-32*i -: 32] !== want[RES_W-1-32*i -: 32])
                report_mismatch($sformatf("%s got %h expected %h", RESULT_FIELDS[i],
                                          got[RES_W-1-32*i -: 32],
                                          want[RES_W-1-32*i -: 32]));
        end
        if (got.bounds_valid !== want.bounds_valid)
            report_mismatch($sformatf("bounds_valid got %b expected %b",
                                      got.bounds_valid, want.bounds_valid));
    endtask

    // Predict on every accepted vertex word, compare every accepted result
    // word. Both are sampled at the rising edge, before the DUT updates.
    always @(posedge clk)
    begin
        res_word_t predicted;
        if (rst_n)
        begin
            if (vtx_valid && vtx_ready)
            begin
                predicted = transform_vertex(vtx_data);
                expected_results.push_back(vtx_gold_on ? vtx_gold : predicted);
            end
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result word %h", res_data));
                else
                    check_result(res_data, expected_results.pop_front());
            end
        end
    end

    // Watchdog: end the run if no word moves on either channel for too long.
    int stuck_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((vtx_valid && vtx_ready) || (res_valid && res_ready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls, plus a long hold-off each time hold_kick flips
    // ------------------------------------------------------------------------
    int   rx_idle_pct = 0;
    logic hold_kick   = 1'b0;
    logic kick_seen   = 1'b0;
    int   hold_left   = 0;

    always @(negedge clk)
    begin
        if (hold_kick != kick_seen)
        begin
            kick_seen = hold_kick;
            hold_left = RX_HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            res_ready <= 1'b0;
        end
        else
            res_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------
    int tx_idle_pct = 0;

    // Offer one vertex word; enter and leave at a falling edge. Valid stays
    // high after acceptance so back-to-back words need no extra assignment.
    task automatic send_vertex(vtx_word_t w, logic gold_on, res_word_t gold);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            vtx_valid <= 1'b0;
            @(negedge clk);
        end
        vtx_valid   <= 1'b1;
        vtx_data    <= w;
        vtx_gold_on <= gold_on;
        vtx_gold    <= gold;
        do
            @(posedge clk);
        while (!vtx_ready);
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected word has come back, then let
    // the pipeline settle.
    task automatic wait_drained();
        vtx_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write one register; only while idle. Out-of-range indexes are dropped.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx < NUM_CFG)
            matrix_regs[idx] = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    function automatic pick_t random_pick();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 12)
            return PICK_SMALL;
        if (roll < 16)
            return PICK_FULL;
        return PICK_EDGE;
    endfunction

    // Random Q16.16 value: small around zero, any pattern, or an extreme.
    function automatic logic [FIELD_W-1:0] rand_fixed(pick_t kind, logic [FIELD_W-1:0] span);
        logic [FIELD_W-1:0] edges [7];
        edges = '{Q_MAX, Q_MIN, 32'h0, Q_ONE, -Q_ONE, 32'h1, 32'hffff_ffff};
        case (kind)
            PICK_SMALL: return $urandom_range(0, 2 * span) - span;
            PICK_FULL:  return $urandom;
            default:    return edges[$urandom_range(0, 6)];
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    vertex_case_t     directed_rows [NUM_ROWS];
    logic [CFG_W-1:0] directed_mats [NUM_MATS][NUM_CFG];

    initial
    begin
        vtx_word_t w;
        pick_t     mat_kind;
        int        sent;
        int        mesh_len;
        bit        noisy;

        // reset matrix is the identity
        matrix_regs[CFG_ROW0_XY] = {Q_ONE, 32'h0};
        matrix_regs[CFG_ROW0_ZT] = '0;
        matrix_regs[CFG_ROW1_XY] = {32'h0, Q_ONE};
        matrix_regs[CFG_ROW1_ZT] = '0;
        matrix_regs[CFG_ROW2_XY] = '0;
        matrix_regs[CFG_ROW2_ZT] = {Q_ONE, 32'h0};
        clear_box();

        // Directed rows; results typed in hold under the identity matrix.
        // Rows cover the coordinate extremes, a mesh of one vertex, and
        // odd raw sums whose half-scale lands on a tie in either sign.
        directed_rows[0] = '{'{0, 0, 0, 1'b1},
                             '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1}};
        directed_rows[1] = '{'{Q_MAX, Q_MIN, 1, 1'b0},
                             '{Q_MAX, Q_MIN, 1, 0, 0, 0, 0, 0, 0, 1'b0}};
        directed_rows[2] = '{'{Q_MIN, Q_MAX, -1, 1'b1},
                             '{Q_MIN, Q_MAX, -1, Q_MIN, Q_MIN, -1, Q_MAX, Q_MAX, 1, 1'b1}};
        directed_rows[3] = '{'{1, -1, -3, 1'b0},
                             '{1, -1, -3, 0, 0, 0, 0, 0, 0, 1'b0}};
        directed_rows[4] = '{'{-Q_ONE, Q_ONE, Q_MIN, 1'b0},
                             '{-Q_ONE, Q_ONE, Q_MIN, 0, 0, 0, 0, 0, 0, 1'b0}};
        directed_rows[5] = '{'{5, -7, 9, 1'b1},
                             '{5, -7, 9, -Q_ONE, -7, Q_MIN, 5, Q_ONE, 9, 1'b1}};

        // matrix 0 stays at reset; then all-max, all-min and half-step
        for (int i = 0; i < NUM_CFG; i++)
        begin
            directed_mats[0][i] = matrix_regs[i];
            directed_mats[1][i] = {Q_MAX, Q_MAX};
            directed_mats[2][i] = {Q_MIN, Q_MIN};
            directed_mats[3][i] = (i % 2 == 1) ? {Q_HALF, 32'h0} : {Q_HALF, Q_HALF};
        end

        // hold reset, then release it on a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part: walk the table once per matrix
        for (int m = 0; m < NUM_MATS; m++)
        begin
            if (m > 0)
            begin
                wait_drained();
                for (int i = 0; i < NUM_CFG; i++)
                    write_reg(cfg_index_t'(i), directed_mats[m][i]);
            end
            for (int r = 0; r < NUM_ROWS; r++)
                send_vertex(directed_rows[r].vtx, m == 0, directed_rows[r].gold);
        end

        // random part: receiver-heavy idling, sender-heavy idling, then none
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            tx_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 59 : 0;
            rx_idle_pct <= (ph == 0) ? 59 : (ph == 1) ? 34 : 0;
            for (int seg = 0; seg < SEGS_PER_PHASE; seg++)
            begin
                // new matrix only with the pipeline empty
                wait_drained();
                mat_kind = random_pick();
                for (int i = 0; i < NUM_CFG; i++)
                    write_reg(cfg_index_t'(i), {rand_fixed(mat_kind, COEF_SPAN),
                                                rand_fixed(mat_kind, COEF_SPAN)});
                if ($urandom_range(0, 2) == 0)
                    write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                              {$urandom, $urandom});

                // with no idling, back up the pipeline behind a long stall
                if (ph == NUM_PHASES - 1 && seg < 2)
                    hold_kick <= ~hold_kick;

                sent = 0;
                while (sent < SEG_ITEMS)
                begin
                    // mostly clean meshes; some carry stray final marks
                    mesh_len = $urandom_range(1, MAX_MESH);
                    noisy    = ($urandom_range(0, 9) == 0);
                    for (int k = 0; k < mesh_len; k++)
                    begin
                        w.pos_x        = rand_fixed(random_pick(), COORD_SPAN);
                        w.pos_y        = rand_fixed(random_pick(), COORD_SPAN);
                        w.pos_z        = rand_fixed(random_pick(), COORD_SPAN);
                        w.final_vertex = (k == mesh_len - 1) ||
                                         (noisy && $urandom_range(0, 3) == 0);
                        send_vertex(w, 1'b0, '0);
                        sent++;
                        // occasionally pause mid-mesh until everything is back
                        if ($urandom_range(0, 60) == 0)
                            wait_drained();
                    end
                end
            end
        end

        // drain, settle, and check nothing is left over
        wait_drained();
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived",
                                      expected_results.size()));
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
